// ===== rtl/core/ccd_pkg.sv =====
`default_nettype none

package ccd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned HALF_W  = 7;
    localparam int unsigned OUT_W   = 16;

    localparam logic [BYTE_W-1:0] RESET_SYNC_FIRST  = 8'hCC;
    localparam logic [BYTE_W-1:0] RESET_SYNC_SECOND = 8'hBA;
    localparam logic [CRC_W-1:0]  CRC_POLY          = 16'h1021;
    localparam logic [CRC_W-1:0]  CHECK_MASK        = 16'h3FFF;

    // configuration register indexes
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_CMD   = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    typedef struct packed {
        logic              frame_ok;
        logic [BYTE_W-1:0] command;
        logic              frame_error;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
    } sync_cfg_t;

    // crc-16 0x1021, msb first, one byte folded in
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        begin
            c = crc ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
            begin
                if (c[CRC_W-1])
                    c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
                else
                    c = {c[CRC_W-2:0], 1'b0};
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccd_cfg_regs.sv =====
`default_nettype none

module ccd_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [ccd_pkg::BYTE_W-1:0] cfg_data,
    output ccd_pkg::sync_cfg_t              cfg
);

    ccd_pkg::sync_cfg_t cfg_reg;
    ccd_pkg::sync_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ccd_pkg::CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data;
                ccd_pkg::CFG_SYNC_SECOND: cfg_next.sync_second = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= ccd_pkg::RESET_SYNC_FIRST;
            cfg_reg.sync_second <= ccd_pkg::RESET_SYNC_SECOND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ccd_parser.sv =====
`default_nettype none

module ccd_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [ccd_pkg::BYTE_W-1:0] rx_byte,
    input  ccd_pkg::sync_cfg_t              cfg,
    output ccd_pkg::result_t                result
);

    ccd_pkg::phase_t               phase_reg, phase_next;
    logic [ccd_pkg::CRC_W-1:0]     crc_reg, crc_next;
    logic [ccd_pkg::BYTE_W-1:0]    cmd_reg, cmd_next;
    logic                          low_ok_reg, low_ok_next;
    logic [ccd_pkg::CRC_W-1:0]     crc_in;
    logic [ccd_pkg::CRC_W-1:0]     crc_step;
    logic [ccd_pkg::BYTE_W-1:0]    check_lo;
    logic [ccd_pkg::BYTE_W-1:0]    check_hi;

    // a new frame starts its crc from zero
    assign crc_in   = (phase_reg == ccd_pkg::PH_HUNT) ? '0 : crc_reg;
    assign crc_step = ccd_pkg::crc_byte(crc_in, rx_byte);
    assign check_lo = {1'b0, crc_reg[ccd_pkg::HALF_W-1:0]};
    assign check_hi = {1'b0, crc_reg[2*ccd_pkg::HALF_W-1:ccd_pkg::HALF_W]};

    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        cmd_next    = cmd_reg;
        low_ok_next = low_ok_reg;
        result      = '0;
        unique case (phase_reg)
            ccd_pkg::PH_HUNT:
            begin
                if (rx_byte == cfg.sync_first)
                begin
                    crc_next   = crc_step;
                    phase_next = ccd_pkg::PH_SYNC2;
                end
            end
            ccd_pkg::PH_SYNC2:
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    crc_next   = crc_step;
                    phase_next = ccd_pkg::PH_CMD;
                end
                else
                begin
                    result.frame_error = 1'b1;
                    phase_next         = ccd_pkg::PH_HUNT;
                    low_ok_next        = 1'b0;
                end
            end
            ccd_pkg::PH_CMD:
            begin
                cmd_next    = rx_byte;
                crc_next    = crc_step & ccd_pkg::CHECK_MASK;
                low_ok_next = 1'b0;
                phase_next  = ccd_pkg::PH_CHECK;
            end
            ccd_pkg::PH_CHECK:
            begin
                if (!low_ok_reg && rx_byte == check_lo)
                begin
                    low_ok_next = 1'b1;
                end
                else if (low_ok_reg && rx_byte == check_hi)
                begin
                    result.frame_ok = 1'b1;
                    result.command  = cmd_reg;
                    phase_next      = ccd_pkg::PH_HUNT;
                    low_ok_next     = 1'b0;
                end
                else
                begin
                    // check byte mismatch, drop the frame and hunt again
                    result.frame_error = 1'b1;
                    phase_next         = ccd_pkg::PH_HUNT;
                    low_ok_next        = 1'b0;
                end
            end
            default:
            begin
                phase_next = ccd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ccd_pkg::PH_HUNT;
            crc_reg    <= '0;
            cmd_reg    <= '0;
            low_ok_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            cmd_reg    <= cmd_next;
            low_ok_reg <= low_ok_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crc_checked_command_deframer_core.sv =====
// flow: each accepted byte waits in byte_reg; its result is then held in result_reg
// throughput: one byte per cycle while m_tready is high; the parser advances once per
// byte and the output register frees the input register whenever the result is taken
// reset (rst_n low, asynchronous): both stages empty, parser hunting for the first
// sync byte, sync registers at 0xcc and 0xba
`default_nettype none

module crc_checked_command_deframer_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [ccd_pkg::OUT_W-1:0]       m_tdata,   // [0] frame_ok, [8:1] command,
                                                       // [9] frame_error, [15:10] zero
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [ccd_pkg::BYTE_W-1:0] cfg_data
);

    logic                       in_valid_reg, in_valid_next;
    logic [ccd_pkg::BYTE_W-1:0] byte_reg;
    logic                       out_valid_reg, out_valid_next;
    ccd_pkg::result_t           result_reg;
    ccd_pkg::result_t           result;
    ccd_pkg::sync_cfg_t         cfg;
    logic                       advance;
    logic                       s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    ccd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            byte_reg <= s_tdata;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, result_reg.frame_error, result_reg.command,
                       result_reg.frame_ok};

endmodule

`default_nettype wire

// ===== rtl/core/ccd_checker.sv =====
`default_nettype none

module ccd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        cfg_we,
    input wire logic        cfg_index,
    input wire logic [7:0]  cfg_data
);

    // a beat never marks a frame as both completed and broken
    a_ok_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("frame_ok and frame_error both set");

    // command only carries data on a good frame
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'h00))
        else $error("command nonzero without frame_ok");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:10] == 6'h00))
        else $error("pad bits of m_tdata set");

    // both stages are empty once reset has been seen at an edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind crc_checked_command_deframer_core ccd_checker u_ccd_checker (.*);

`default_nettype wire
